[rtl/sqw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqw_pkg
// Shared types, codes and tables for the square-wave sound channel.
// ----------------------------------------------------------------------------
package sqw_pkg;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_TICK   = 2'd1,
    OP_LENGTH = 2'd2,
    OP_ENV    = 2'd3
  } sqw_op_t;

  localparam logic [2:0] REG_DUTY = 3'd1;
  localparam logic [2:0] REG_ENV  = 3'd2;
  localparam logic [2:0] REG_LO   = 3'd3;
  localparam logic [2:0] REG_HI   = 3'd4;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_WR_DUTY,
    CMD_WR_ENV,
    CMD_WR_LO,
    CMD_WR_HI,
    CMD_TICK,
    CMD_LENGTH,
    CMD_ENV
  } sqw_kind_t;

  typedef struct packed {
    sqw_kind_t  kind;
    logic [7:0] data;
  } sqw_cmd_t;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int TIMER_W  = 14;
  localparam int TONE_W   = 11;
  localparam int LEN_W    = 7;
  localparam logic [LEN_W-1:0] LEN_FULL = 7'd64;

  function automatic logic duty_bit(input logic [1:0] sel, input logic [2:0] pos);
    logic [7:0] pat;
    case (sel)
      2'd0:    pat = 8'h80;
      2'd1:    pat = 8'h81;
      2'd2:    pat = 8'hE1;
      default: pat = 8'h7E;
    endcase
    return pat[pos];
  endfunction

endpackage

[rtl/sqw_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqw_front
// Accept input requests and classify them into channel commands.
// ----------------------------------------------------------------------------
module sqw_front (
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_op,
  input  logic [2:0]        in_reg_index,
  input  logic [7:0]        in_write_value,
  input  logic              q_full,
  output logic              push,
  output sqw_pkg::sqw_cmd_t cmd
);
  import sqw_pkg::*;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    cmd.data = in_write_value;
    case (sqw_op_t'(in_op))
      OP_WRITE: begin
        case (in_reg_index)
          REG_DUTY: cmd.kind = CMD_WR_DUTY;
          REG_ENV:  cmd.kind = CMD_WR_ENV;
          REG_LO:   cmd.kind = CMD_WR_LO;
          REG_HI:   cmd.kind = CMD_WR_HI;
          default:  cmd.kind = CMD_NOP;
        endcase
      end
      OP_TICK:   cmd.kind = CMD_TICK;
      OP_LENGTH: cmd.kind = CMD_LENGTH;
      default:   cmd.kind = CMD_ENV;
    endcase
  end

endmodule

[rtl/sqw_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqw_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module sqw_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sqw_pkg::sqw_cmd_t push_cmd,
  output logic              full,
  output logic              q_valid,
  input  logic              pop,
  output sqw_pkg::sqw_cmd_t pop_cmd
);
  import sqw_pkg::*;

  sqw_cmd_t            slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r,  count_nxt;

  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign pop_cmd = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || full) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("pop from empty queue");
`endif

endmodule

[rtl/sqw_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqw_back
// Channel state: apply commands, form the sample and hold the result.
// ----------------------------------------------------------------------------
module sqw_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  sqw_pkg::sqw_cmd_t cmd,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [3:0]        out_sample,
  output logic              out_length_active
);
  import sqw_pkg::*;

  logic [TIMER_W-1:0] timer_r,   timer_nxt;
  logic [2:0]         wave_r,    wave_nxt;
  logic [1:0]         duty_r,    duty_nxt;
  logic [LEN_W-1:0]   len_r,     len_nxt;
  logic               dac_r,     dac_nxt;
  logic [3:0]         svol_r,    svol_nxt;
  logic [3:0]         vol_r,     vol_nxt;
  logic               rise_r,    rise_nxt;
  logic [2:0]         eper_r,    eper_nxt;
  logic [3:0]         ecnt_r,    ecnt_nxt;
  logic [TONE_W-1:0]  tone_r,    tone_nxt;
  logic               len_on_r,  len_on_nxt;
  logic               ch_on_r,   ch_on_nxt;
  logic               erun_r,    erun_nxt;
  logic               ovalid_r,  ovalid_nxt;
  logic [3:0]         osmp_r,    osmp_nxt;
  logic               olen_r,    olen_nxt;
  logic [TIMER_W-1:0] reload_cur;

  assign pop        = q_valid && (!ovalid_r || !out_stall);
  assign out_valid  = ovalid_r;
  assign out_sample = osmp_r;
  assign out_length_active = olen_r;

  assign reload_cur = {12'd2048 - {1'b0, tone_r}, 2'b00};

  always_comb begin
    logic [TONE_W-1:0] tone_hi;
    logic [3:0]        vol_env;
    tone_hi    = {cmd.data[2:0], tone_r[7:0]};
    vol_env    = vol_r;
    timer_nxt  = timer_r;
    wave_nxt   = wave_r;
    duty_nxt   = duty_r;
    len_nxt    = len_r;
    dac_nxt    = dac_r;
    svol_nxt   = svol_r;
    vol_nxt    = vol_r;
    rise_nxt   = rise_r;
    eper_nxt   = eper_r;
    ecnt_nxt   = ecnt_r;
    tone_nxt   = tone_r;
    len_on_nxt = len_on_r;
    ch_on_nxt  = ch_on_r;
    erun_nxt   = erun_r;
    if (pop) begin
      case (cmd.kind)
        CMD_WR_DUTY: begin
          duty_nxt = cmd.data[7:6];
          len_nxt  = LEN_FULL - {1'b0, cmd.data[5:0]};
        end
        CMD_WR_ENV: begin
          dac_nxt  = (cmd.data[7:3] != 5'd0);
          svol_nxt = cmd.data[7:4];
          vol_nxt  = cmd.data[7:4];
          rise_nxt = cmd.data[3];
          eper_nxt = cmd.data[2:0];
          ecnt_nxt = {1'b0, cmd.data[2:0]};
        end
        CMD_WR_LO: begin
          tone_nxt = {tone_r[10:8], cmd.data};
        end
        CMD_WR_HI: begin
          tone_nxt   = tone_hi;
          len_on_nxt = cmd.data[6];
          if (cmd.data[7]) begin
            ch_on_nxt = 1'b1;
            if (len_r == '0) begin
              len_nxt = LEN_FULL;
            end
            timer_nxt = {12'd2048 - {1'b0, tone_hi}, 2'b00};
            vol_nxt   = svol_r;
            ecnt_nxt  = {1'b0, eper_r};
            erun_nxt  = 1'b1;
          end
        end
        CMD_TICK: begin
          if (timer_r <= TIMER_W'(1)) begin
            timer_nxt = reload_cur;
            wave_nxt  = wave_r + 3'd1;
          end else begin
            timer_nxt = timer_r - 1'b1;
          end
        end
        CMD_LENGTH: begin
          if (len_on_r && len_r != '0) begin
            len_nxt = len_r - 1'b1;
            if (len_r == LEN_W'(1)) begin
              ch_on_nxt = 1'b0;
            end
          end
        end
        CMD_ENV: begin
          if (erun_r) begin
            if (ecnt_r <= 4'd1) begin
              ecnt_nxt = (eper_r != 3'd0) ? {1'b0, eper_r} : 4'd8;
              if (eper_r != 3'd0) begin
                if (rise_r && vol_r != 4'd15) begin
                  vol_env = vol_r + 4'd1;
                end else if (!rise_r && vol_r != 4'd0) begin
                  vol_env = vol_r - 4'd1;
                end
              end
              vol_nxt = vol_env;
              if (vol_env == 4'd0 || vol_env == 4'd15) begin
                erun_nxt = 1'b0;
              end
            end else begin
              ecnt_nxt = ecnt_r - 4'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    osmp_nxt   = osmp_r;
    olen_nxt   = olen_r;
    ovalid_nxt = ovalid_r && out_stall;
    if (pop) begin
      ovalid_nxt = 1'b1;
      osmp_nxt   = (ch_on_nxt && dac_nxt && duty_bit(duty_nxt, wave_nxt)) ? vol_nxt : 4'd0;
      olen_nxt   = (len_nxt != '0) || !len_on_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_r  <= TIMER_W'(8192);
      wave_r   <= '0;
      duty_r   <= '0;
      len_r    <= '0;
      dac_r    <= 1'b0;
      svol_r   <= '0;
      vol_r    <= '0;
      rise_r   <= 1'b0;
      eper_r   <= '0;
      ecnt_r   <= '0;
      tone_r   <= '0;
      len_on_r <= 1'b0;
      ch_on_r  <= 1'b0;
      erun_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      timer_r  <= timer_nxt;
      wave_r   <= wave_nxt;
      duty_r   <= duty_nxt;
      len_r    <= len_nxt;
      dac_r    <= dac_nxt;
      svol_r   <= svol_nxt;
      vol_r    <= vol_nxt;
      rise_r   <= rise_nxt;
      eper_r   <= eper_nxt;
      ecnt_r   <= ecnt_nxt;
      tone_r   <= tone_nxt;
      len_on_r <= len_on_nxt;
      ch_on_r  <= ch_on_nxt;
      erun_r   <= erun_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    osmp_r <= osmp_nxt;
    olen_r <= olen_nxt;
  end

`ifndef SYNTH
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_FULL)
    else $error("length counter beyond 64");
  a_sample_gated: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && osmp_r != 4'd0) |-> (ch_on_r && dac_r && osmp_r == vol_r))
    else $error("sample driven while channel or DAC off");
  a_env_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && cmd.kind == CMD_ENV && erun_r && ecnt_r <= 4'd1 && eper_r != 3'd0)
      |=> (!erun_r || (vol_r != 4'd0 && vol_r != 4'd15)))
    else $error("envelope kept running at a volume limit");
  a_len_active: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !olen_r) |-> (len_on_r && len_r == '0))
    else $error("length status disagrees with counter");
`endif

endmodule

[rtl/square_wave_sound_channel.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// square_wave_sound_channel
// Square-wave channel with duty patterns, length counter and volume envelope.
// ----------------------------------------------------------------------------
// A request is written into a queue slot when it is accepted; the back part
// then pops it into the registered state and output (queue slot, then state
// update). Throughput: 1 request per cycle while in_stall is low.
// The 4-entry command queue absorbs output stalls before in_stall rises.
// Reset (rst_n low, synchronous): channel state to power-on values, queue
// and output emptied. No clearing pass.
module square_wave_sound_channel (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_op,
  input  logic [2:0] in_reg_index,
  input  logic [7:0] in_write_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_sample,
  output logic       out_length_active
);
  import sqw_pkg::*;

  sqw_cmd_t front_cmd;
  sqw_cmd_t back_cmd;
  logic     push;
  logic     q_full;
  logic     q_valid;
  logic     pop;

  sqw_front u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_reg_index   (in_reg_index),
    .in_write_value (in_write_value),
    .q_full         (q_full),
    .push           (push),
    .cmd            (front_cmd)
  );

  sqw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (front_cmd),
    .full     (q_full),
    .q_valid  (q_valid),
    .pop      (pop),
    .pop_cmd  (back_cmd)
  );

  sqw_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .cmd               (back_cmd),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sample        (out_sample),
    .out_length_active (out_length_active)
  );

endmodule
